[rtl/scc_pkg.sv]
package scc_pkg;

  // Vertex capacity and field widths
  localparam int unsigned NumVert = 32;
  localparam int unsigned VertW   = 5;
  localparam int unsigned CntW    = 6;

  typedef logic [VertW-1:0]   vert_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [NumVert-1:0] row_t;

  // Register map: register index is byte address bit 2
  localparam logic RegVertexCount   = 1'b0;
  localparam cnt_t VertexCountReset = cnt_t'(32);

  // Edge write request into the adjacency memory
  typedef struct packed {
    logic  valid;
    vert_t row;
    vert_t col;
  } edge_req_t;

  // Row read request from the search engine
  typedef struct packed {
    logic  en;
    vert_t addr;
  } rd_req_t;

  // Search engine status
  typedef struct packed {
    logic busy;
    logic done;
    logic closed;
  } srch_stat_t;

endpackage

[rtl/scc_adj.sv]
module scc_adj import scc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      clr_i,
  input  edge_req_t edge_i,
  input  rd_req_t   rd_i,
  output row_t      row_o
);

  row_t      mem_q [NumVert];
  row_t      rdata_q;
  row_t      row_vld_q;
  logic      rv_q;
  logic      hit_q;
  edge_req_t pend_q;
  logic      fwd_vld_q;
  vert_t     fwd_row_q;
  row_t      fwd_data_q;
  vert_t     raddr;
  row_t      base;
  row_t      merged;

  // Edge loads take the read port ahead of the search
  assign raddr = edge_i.valid ? edge_i.row : rd_i.addr;

  // Take the row written in the read cycle; rows never written since the
  // last clear read as zero
  assign row_o = hit_q ? fwd_data_q : (rv_q ? rdata_q : '0);

  // Forward the row written last cycle, its read saw the old value
  assign base   = (fwd_vld_q && (fwd_row_q == pend_q.row)) ? fwd_data_q : row_o;
  assign merged = base | (row_t'(1) << pend_q.col);

  // Memory read and write-back
  always_ff @(posedge clk_i) begin
    if (edge_i.valid || rd_i.en) begin
      rdata_q <= mem_q[raddr];
    end
    if (pend_q.valid) begin
      mem_q[pend_q.row] <= merged;
    end
    fwd_row_q  <= pend_q.row;
    fwd_data_q <= merged;
  end

  // Row valid bits and pending write stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rv_q      <= 1'b0;
      hit_q     <= 1'b0;
      pend_q    <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      pend_q    <= edge_i;
      fwd_vld_q <= pend_q.valid;
      if (edge_i.valid || rd_i.en) begin
        rv_q  <= row_vld_q[raddr];
        hit_q <= pend_q.valid && (pend_q.row == raddr);
      end
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (pend_q.valid) begin
        row_vld_q[pend_q.row] <= 1'b1;
      end
    end
  end

endmodule

[rtl/scc_search.sv]
module scc_search import scc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  cnt_t       n_i,
  input  row_t       row_i,
  output rd_req_t    rd_o,
  output srch_stat_t stat_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ROOT = 9'b000000010,
    S_LOAD = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_ORD  = 9'b000010000,
    S_FIN  = 9'b000100000,
    S_POP  = 9'b001000000,
    S_RET  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  typedef struct packed {
    vert_t v;
    cnt_t  nxt;
    cnt_t  low;
    cnt_t  ord;
  } call_t;

  state_e state_q;
  cnt_t   r_q;
  cnt_t   ocnt_q;
  row_t   vis_q;
  row_t   onstk_q;
  cnt_t   vsp_q;
  cnt_t   csp_q;
  logic   closed_q;
  vert_t  vstk_q [NumVert];
  call_t  cstk_q [NumVert];
  cnt_t   omem_q [NumVert];
  cnt_t   ord_rd_q;
  call_t  cur_q;
  row_t   row_q;

  cnt_t   nxt;
  vert_t  nv;
  cnt_t   vsp_m1;
  cnt_t   csp_m1;
  cnt_t   csp_m2;
  vert_t  top_w;
  call_t  parent;
  logic   push_en;
  vert_t  push_v;
  logic   nxt_in;

  assign nxt    = cur_q.nxt;
  assign nv     = nxt[VertW-1:0];
  assign nxt_in = nxt < n_i;
  assign vsp_m1 = vsp_q - cnt_t'(1);
  assign csp_m1 = csp_q - cnt_t'(1);
  assign csp_m2 = csp_q - cnt_t'(2);
  assign top_w  = vstk_q[vsp_m1[VertW-1:0]];
  assign parent = cstk_q[csp_m2[VertW-1:0]];

  // Decode vertex pushes and row reads
  always_comb begin
    push_en = 1'b0;
    push_v  = '0;
    rd_o    = '0;
    case (state_q)
      S_ROOT: begin
        if ((r_q < n_i) && !vis_q[r_q[VertW-1:0]]) begin
          push_en = 1'b1;
          push_v  = r_q[VertW-1:0];
        end
      end
      S_SCAN: begin
        if (nxt_in && row_q[nv] && !vis_q[nv]) begin
          push_en = 1'b1;
          push_v  = nv;
        end
      end
      S_RET: begin
        if (csp_q > cnt_t'(1)) begin
          rd_o.en   = 1'b1;
          rd_o.addr = parent.v;
        end
      end
      default: ;
    endcase
    if (push_en) begin
      rd_o.en   = 1'b1;
      rd_o.addr = push_v;
    end
  end

  assign stat_o.busy   = (state_q != S_IDLE);
  assign stat_o.done   = (state_q == S_DONE);
  assign stat_o.closed = closed_q;

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      r_q      <= '0;
      ocnt_q   <= '0;
      vis_q    <= '0;
      onstk_q  <= '0;
      vsp_q    <= '0;
      csp_q    <= '0;
      closed_q <= 1'b1;
    end else begin
      if (push_en) begin
        vis_q[push_v]   <= 1'b1;
        onstk_q[push_v] <= 1'b1;
        vsp_q           <= vsp_q + cnt_t'(1);
        csp_q           <= csp_q + cnt_t'(1);
        ocnt_q          <= ocnt_q + cnt_t'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            vis_q    <= '0;
            onstk_q  <= '0;
            vsp_q    <= '0;
            csp_q    <= '0;
            ocnt_q   <= '0;
            r_q      <= '0;
            closed_q <= 1'b1;
            state_q  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (r_q >= n_i) begin
            state_q <= S_DONE;
          end else begin
            r_q <= r_q + cnt_t'(1);
            if (push_en) begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: state_q <= S_SCAN;
        S_SCAN: begin
          if (!nxt_in) begin
            state_q <= S_FIN;
          end else if (row_q[nv]) begin
            if (!vis_q[nv]) begin
              state_q <= S_LOAD;
            end else if (onstk_q[nv]) begin
              state_q <= S_ORD;
            end else begin
              // edge into a finished component
              closed_q <= 1'b0;
            end
          end
        end
        S_ORD: state_q <= S_SCAN;
        S_FIN: begin
          if (cur_q.low == cur_q.ord) begin
            // tree edge from the parent leaves this component
            if (csp_q > cnt_t'(1)) begin
              closed_q <= 1'b0;
            end
            state_q <= S_POP;
          end else begin
            state_q <= S_RET;
          end
        end
        S_POP: begin
          onstk_q[top_w] <= 1'b0;
          vsp_q          <= vsp_m1;
          if (top_w == cur_q.v) begin
            state_q <= S_RET;
          end
        end
        S_RET: begin
          csp_q   <= csp_m1;
          state_q <= (csp_q == cnt_t'(1)) ? S_ROOT : S_LOAD;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Stacks, visit order memory and current frame
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      ord_rd_q <= omem_q[nv];
    end
    if (state_q == S_LOAD) begin
      row_q <= row_i;
    end
    if (push_en) begin
      vstk_q[vsp_q[VertW-1:0]] <= push_v;
      omem_q[push_v]           <= ocnt_q;
      if (csp_q != '0) begin
        cstk_q[csp_m1[VertW-1:0]] <= '{v: cur_q.v, nxt: nxt + cnt_t'(1),
                                       low: cur_q.low, ord: cur_q.ord};
      end
      cur_q <= '{v: push_v, nxt: '0, low: ocnt_q, ord: ocnt_q};
    end else if ((state_q == S_SCAN) && nxt_in) begin
      cur_q.nxt <= nxt + cnt_t'(1);
    end else if (state_q == S_ORD) begin
      if (ord_rd_q < cur_q.low) begin
        cur_q.low <= ord_rd_q;
      end
    end else if ((state_q == S_RET) && (csp_q > cnt_t'(1))) begin
      cur_q <= '{v: parent.v, nxt: parent.nxt,
                 low: (cur_q.low < parent.low) ? cur_q.low : parent.low,
                 ord: parent.ord};
    end
  end

endmodule

[rtl/scc_edge_closure_check_unit.sv]
// Channel   Handshake              Payload
// request   start_i / busy_o       from_vertex_i, to_vertex_i, edge_valid_i, last_i
// result    done_o (1-cycle)       closed_components_o, range_error_o
// config    APB psel/penable       paddr, pwdata, prdata (vertex_count at 0x0)
//
// Edges load one per cycle while busy_o is low; a row write waits in the pending
// stage before it lands and is forwarded to any read of that row in the same cycle.
// A last request starts the component search, busy_o high until done_o: per
// vertex a row load, n+1 column scans, one extra per edge into the open stack,
// finish, pop, return and a parent reload.
// Reset and each result clear the matrix through row valid bits at once;
// the receiver cannot stall, done_o is shown for exactly one cycle.
module scc_edge_closure_check_unit import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  from_vertex_i,
  input  logic [4:0]  to_vertex_i,
  input  logic        edge_valid_i,
  input  logic        last_i,
  output logic        done_o,
  output logic        closed_components_o,
  output logic        range_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cnt_t       vcount_q;
  cnt_t       n_eff;
  logic       err_q;
  logic       accept;
  logic       in_range;
  edge_req_t  edge_req;
  rd_req_t    rd_req;
  row_t       row;
  srch_stat_t stat;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegVertexCount) ? {26'd0, vcount_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegVertexCount)) begin
      vcount_q <= pwdata[CntW-1:0];
    end
  end

  // Saturate the count at the vertex capacity
  assign n_eff = (vcount_q > cnt_t'(NumVert)) ? cnt_t'(NumVert) : vcount_q;

  assign busy_o   = stat.busy;
  assign accept   = start_i && !busy_o;
  assign in_range = ({1'b0, from_vertex_i} < n_eff) && ({1'b0, to_vertex_i} < n_eff);

  assign edge_req.valid = accept && edge_valid_i && in_range;
  assign edge_req.row   = from_vertex_i;
  assign edge_req.col   = to_vertex_i;

  // Track out-of-range edges for the current graph
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (stat.done) begin
      err_q <= 1'b0;
    end else if (accept && edge_valid_i && !in_range) begin
      err_q <= 1'b1;
    end
  end

  scc_adj u_adj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (stat.done),
    .edge_i (edge_req),
    .rd_i   (rd_req),
    .row_o  (row)
  );

  scc_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && last_i),
    .n_i     (n_eff),
    .row_i   (row),
    .rd_o    (rd_req),
    .stat_o  (stat)
  );

  assign done_o              = stat.done;
  assign closed_components_o = stat.closed;
  assign range_error_o       = err_q;

endmodule

[rtl/scc_chk.sv]
module scc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        last_i,
  input logic        done_o,
  input logic        psel,
  input logic        pready
);

  // A result only ends a busy search
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside search");

  // A last request starts the search
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o) else $error("last request not taken");

  // Release after the result
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after result");

  // No result straight out of idle
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !done_o) else $error("result without search");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready) else $error("pready low");

endmodule

bind scc_edge_closure_check_unit scc_chk u_chk (.*);

[tb/tb.sv]
module tb;
  import scc_pkg::*;

  // Edge-set model of one graph; answers the component closure question
  class closure_board;
    bit          adj [NumVert][NumVert];
    bit          err_seen;
    int unsigned vcount;
    bit          want_closed [$];
    bit          want_err [$];
    int          errors;
    int          graphs;

    function void clear_graph();
      foreach (adj[a, b]) adj[a][b] = 1'b0;
      err_seen = 1'b0;
    endfunction

    // Reachability closure: an edge a->b is inside a component iff b reaches a
    function bit graph_closed(int unsigned n);
      bit reach [NumVert][NumVert];
      for (int a = 0; a < n; a++)
        for (int b = 0; b < n; b++)
          reach[a][b] = adj[a][b] || (a == b);
      for (int k = 0; k < n; k++)
        for (int a = 0; a < n; a++)
          if (reach[a][k])
            for (int b = 0; b < n; b++)
              if (reach[k][b]) reach[a][b] = 1'b1;
      for (int a = 0; a < n; a++)
        for (int b = 0; b < n; b++)
          if (adj[a][b] && !reach[b][a]) return 1'b0;
      return 1'b1;
    endfunction

    // Note an accepted request
    function void note_request(vert_t f, vert_t t, bit v, bit l);
      int unsigned n;
      n = (vcount > NumVert) ? NumVert : vcount;
      if (v) begin
        if (f >= n || t >= n) err_seen = 1'b1;
        else adj[f][t] = 1'b1;
      end
      if (l) begin
        want_closed = {want_closed, graph_closed(n)};
        want_err    = {want_err, err_seen};
        clear_graph();
      end
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Check one result against the oldest expectation
    task check_result(bit c, bit e);
      graphs++;
      if (want_closed.size() == 0) begin
        report("result with no pending request");
        return;
      end
      if (want_closed[0] != c)
        report($sformatf("closed_components got %0b want %0b", c, want_closed[0]));
      if (want_err[0] != e)
        report($sformatf("range_error got %0b want %0b", e, want_err[0]));
      void'(want_closed.pop_front());
      void'(want_err.pop_front());
    endtask
  endclass

  logic        clk_i, rst_ni, start_i, busy_o;
  logic [4:0]  from_vertex_i, to_vertex_i;
  logic        edge_valid_i, last_i, done_o, closed_components_o, range_error_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  scc_edge_closure_check_unit dut (.*);

  closure_board board;
  int  idle_cycles;
  bit  quiet;
  int  sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check results and count stalled cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_result(closed_components_o, range_error_o);
      if (done_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Watchdog expired");
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_request(vert_t f, vert_t t, bit v, bit l);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    from_vertex_i <= f;
    to_vertex_i   <= t;
    edge_valid_i  <= v;
    last_i        <= l;
    do @(posedge clk_i); while (busy_o);
    board.note_request(f, t, v, l);
    sent++;
  endtask

  // Drain pending results, then write vertex_count
  task automatic set_vertex_count(int unsigned n);
    start_i <= 1'b0;
    while (board.want_closed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {RegVertexCount, 2'b00}; pwdata <= n;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.vcount = n & 6'h3f;
  endtask

  // Random graph: mostly edges over in-range vertices, some noise
  task automatic send_graph(int unsigned n, int len);
    vert_t f, t;
    int unsigned span;
    span = (n == 0) ? 1 : ((n > NumVert) ? NumVert : n);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        f = vert_t'($urandom_range(0, span - 1));
        t = vert_t'($urandom_range(0, span - 1));
      end else begin
        f = vert_t'($urandom); t = vert_t'($urandom);
      end
      send_request(f, t, $urandom_range(0, 7) != 0, k == len - 1);
    end
  endtask

  initial begin
    int unsigned counts [6];
    counts = '{32, 1, 0, 63, 7, 20};
    board = new();
    board.vcount = 32;
    board.clear_graph();
    start_i = 0; from_vertex_i = 0; to_vertex_i = 0; edge_valid_i = 0; last_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    quiet = 0; sent = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, self loop, closed ring, broken rings, extremes
    send_request(5'd0, 5'd0, 1'b0, 1'b1);
    send_request(5'd5, 5'd5, 1'b1, 1'b1);
    send_request(5'd0, 5'd31, 1'b1, 1'b0);
    send_request(5'd31, 5'd0, 1'b1, 1'b1);
    send_request(5'd0, 5'd31, 1'b1, 1'b0);
    send_request(5'd0, 5'd31, 1'b1, 1'b1);
    send_request(5'd1, 5'd2, 1'b1, 1'b0);
    send_request(5'd2, 5'd3, 1'b1, 1'b0);
    send_request(5'd3, 5'd1, 1'b1, 1'b0);
    send_request(5'd3, 5'd4, 1'b1, 1'b1);
    set_vertex_count(1);
    send_request(5'd0, 5'd0, 1'b1, 1'b0);
    send_request(5'd0, 5'd1, 1'b1, 1'b1);
    set_vertex_count(0);
    send_request(5'd0, 5'd0, 1'b1, 1'b0);
    send_request(5'd0, 5'd0, 1'b0, 1'b1);
    set_vertex_count(63);
    send_request(5'd31, 5'd31, 1'b1, 1'b0);
    send_request(5'd30, 5'd31, 1'b1, 1'b1);
    set_vertex_count(4);
    send_request(5'd3, 5'd3, 1'b1, 1'b0);
    send_request(5'd2, 5'd3, 1'b1, 1'b0);
    send_request(5'd3, 5'd2, 1'b1, 1'b1);

    // Random phases over several vertex counts
    for (int ph = 0; ph < 12; ph++) begin
      set_vertex_count(ph < 6 ? counts[ph] : $urandom_range(0, 63));
      if (ph == 10) quiet = 1;
      while (sent < 140 * (ph + 1) + 20)
        send_graph(board.vcount, $urandom_range(1, 24));
    end

    start_i <= 1'b0;
    while (board.want_closed.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    $display("Sent %0d edge requests, checked %0d graphs over vertex counts 0 to 63",
             sent, board.graphs);
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
